@@ rtl/kar_pkg.sv @@
package kar_pkg;

  localparam int NUM_KEYS   = 64;
  localparam int KEY_W      = $clog2(NUM_KEYS);
  localparam int KEY_CODE_W = 6;
  localparam int ELAPSED_W  = 24;
  localparam int TIME_W     = 32;
  localparam int MASK_W     = 64;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_TICK    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_PRESSED   = 2'd1,
    MODE_REPEATING = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WALK  = 2'd1,
    ST_FLUSH = 2'd2
  } state_e;

  localparam logic [1:0] REG_START_DELAY    = 2'd0;
  localparam logic [1:0] REG_REPEAT_DELAY   = 2'd1;
  localparam logic [1:0] REG_NO_REPEAT_MASK = 2'd2;

  typedef struct packed {
    logic [1:0]            kind;
    logic [KEY_CODE_W-1:0] key_code;
    logic [ELAPSED_W-1:0]  elapsed;
  } in_t;

  typedef struct packed {
    logic [KEY_CODE_W-1:0] out_key;
    logic                  is_release;
    logic                  last;
  } out_t;

  typedef struct packed {
    mode_e             mode;
    logic [TIME_W-1:0] held;
  } entry_t;

endpackage

@@ rtl/keyboard_auto_repeat.sv @@
// Typematic key repeat engine. Each key's mode and held time live in one
// synchronous key table of NUM_KEYS entries, read and written back once per
// cycle. A press or release request visits one key entry; a tick request
// walks every key entry, one entry per cycle through the table's read port
// while the result side does not stall. The last event of a request is
// known only when the walk ends, so one event is held back until the next
// one or the end of the walk. No clearing pass is needed after reset: a
// valid bit per key makes an unwritten entry read as idle. Configuration
// must be written through the register port only while idle; it is not checked.
module keyboard_auto_repeat
  import kar_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [TIME_W-1:0] start_delay_q, repeat_delay_q;
  logic [MASK_W-1:0] no_repeat_mask_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q    <= TIME_W'(5000000);
      repeat_delay_q   <= TIME_W'(500000);
      no_repeat_mask_q <= '0;
    end else if (cfg_we) begin
      case (paddr[4:3])
        REG_START_DELAY:    start_delay_q    <= pwdata[TIME_W-1:0];
        REG_REPEAT_DELAY:   repeat_delay_q   <= pwdata[TIME_W-1:0];
        REG_NO_REPEAT_MASK: no_repeat_mask_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_START_DELAY:    prdata = {32'd0, start_delay_q};
      REG_REPEAT_DELAY:   prdata = {32'd0, repeat_delay_q};
      REG_NO_REPEAT_MASK: prdata = no_repeat_mask_q;
      default:            prdata = '0;
    endcase
  end

  // Sequencer and pipeline registers.
  state_e                state_q, state_d;
  in_t                   item_q, item_d;
  logic [KEY_W-1:0]      rd_idx_q, rd_idx_d;
  logic                  rd_more_q, rd_more_d;
  logic                  p_valid_q, p_valid_d;
  logic [KEY_W-1:0]      p_key_q, p_key_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [KEY_CODE_W-1:0] pend_key_q, pend_key_d;
  logic                  pend_rel_q, pend_rel_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;
  logic [NUM_KEYS-1:0]   key_valid_q, key_valid_d;

  // Key table.
  entry_t mem [NUM_KEYS];
  entry_t rdata_q;
  entry_t wdata;
  logic   mem_we, rd_en;

  logic                  in_accept, out_free, key_in_range;
  logic                  advance, p_done, emit, rel, wr;
  logic                  flush_push, walk_push;
  mode_e                 cur_mode;
  logic [TIME_W:0]       sum;
  logic [TIME_W-1:0]     t_sat;
  logic                  may_repeat;
  logic [KEY_CODE_W-1:0] p_key_code;

  assign in_accept    = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign key_in_range = {1'b0, in_data_i.key_code} < (KEY_CODE_W + 1)'(NUM_KEYS);
  assign p_key_code   = KEY_CODE_W'(p_key_q);

  // Read-modify-write of the entry in the process stage.
  always_comb begin
    cur_mode   = key_valid_q[p_key_q] ? rdata_q.mode : MODE_IDLE;
    sum        = {1'b0, rdata_q.held} + {{(TIME_W + 1 - ELAPSED_W){1'b0}}, item_q.elapsed};
    t_sat      = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    may_repeat = !no_repeat_mask_q[p_key_code];
    emit       = 1'b0;
    rel        = 1'b0;
    wr         = 1'b0;
    wdata      = rdata_q;
    case (kind_e'(item_q.kind))
      KIND_PRESS: begin
        wr         = 1'b1;
        emit       = 1'b1;
        wdata.mode = MODE_PRESSED;
        wdata.held = '0;
      end
      KIND_RELEASE: begin
        if (cur_mode != MODE_IDLE) begin
          wr         = 1'b1;
          emit       = 1'b1;
          rel        = 1'b1;
          wdata.mode = MODE_IDLE;
        end
      end
      KIND_TICK: begin
        if (cur_mode != MODE_IDLE) begin
          wr         = 1'b1;
          wdata.mode = cur_mode;
          wdata.held = t_sat;
          if (cur_mode == MODE_PRESSED && may_repeat && t_sat >= start_delay_q) begin
            emit       = 1'b1;
            wdata.mode = MODE_REPEATING;
            wdata.held = '0;
          end else if (cur_mode == MODE_REPEATING && t_sat >= repeat_delay_q) begin
            emit       = 1'b1;
            wdata.held = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // An event can only be parked once the one already parked has moved on.
  assign p_done     = !emit || !pend_valid_q || out_free;
  assign advance    = !p_valid_q || p_done;
  assign rd_en      = (state_q == ST_WALK) && rd_more_q && advance;
  assign mem_we     = p_valid_q && p_done && wr;
  assign walk_push  = p_valid_q && emit && pend_valid_q && out_free;
  assign flush_push = (state_q == ST_FLUSH) && pend_valid_q && out_free;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[p_key_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_idx_q];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (kind_e'(in_data_i.kind) == KIND_TICK) begin
            state_d = ST_WALK;
          end else if ((kind_e'(in_data_i.kind) == KIND_PRESS ||
                        kind_e'(in_data_i.kind) == KIND_RELEASE) && key_in_range) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_WALK: begin
        if (!rd_more_q && !p_valid_q) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath registers.
  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    item_d       = item_q;
    rd_idx_d     = rd_idx_q;
    rd_more_d    = rd_more_q;
    p_valid_d    = p_valid_q;
    p_key_d      = p_key_q;
    pend_valid_d = pend_valid_q;
    pend_key_d   = pend_key_q;
    pend_rel_d   = pend_rel_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    key_valid_d  = key_valid_q;

    if (in_accept) begin
      item_d    = in_data_i;
      rd_more_d = 1'b1;
      if (kind_e'(in_data_i.kind) == KIND_TICK) begin
        rd_idx_d = '0;
      end else begin
        rd_idx_d = in_data_i.key_code[KEY_W-1:0];
      end
    end

    if (rd_en) begin
      if (kind_e'(item_q.kind) == KIND_TICK && rd_idx_q != KEY_W'(NUM_KEYS - 1)) begin
        rd_idx_d = rd_idx_q + 1'b1;
      end else begin
        rd_more_d = 1'b0;
      end
    end

    if (advance) begin
      p_valid_d = rd_en;
      p_key_d   = rd_idx_q;
    end

    if (mem_we) begin
      key_valid_d[p_key_q] = 1'b1;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (walk_push || flush_push) begin
      out_valid_d      = 1'b1;
      out_d.out_key    = pend_key_q;
      out_d.is_release = pend_rel_q;
      out_d.last       = flush_push;
    end

    if (flush_push) begin
      pend_valid_d = 1'b0;
    end
    if (p_valid_q && p_done && emit) begin
      pend_valid_d = 1'b1;
      pend_key_d   = p_key_code;
      pend_rel_d   = rel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_more_q    <= 1'b0;
      p_valid_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      key_valid_q  <= '0;
    end else begin
      state_q      <= state_d;
      rd_more_q    <= rd_more_d;
      p_valid_q    <= p_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      key_valid_q  <= key_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    rd_idx_q   <= rd_idx_d;
    p_key_q    <= p_key_d;
    pend_key_q <= pend_key_d;
    pend_rel_q <= pend_rel_d;
    out_q      <= out_d;
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import kar_pkg::*;

  localparam int          CYCLE_LIMIT   = 4_000_000;
  localparam int          SETTLE_CYCLES = 2 * NUM_KEYS + 20;
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;
  localparam logic [31:0] START_RESET   = 32'd5_000_000;
  localparam logic [31:0] REPEAT_RESET  = 32'd500_000;

  typedef enum logic [1:0] {
    RX_FREE    = 2'd0,
    RX_BLOCKED = 2'd1,
    RX_CHOPPY  = 2'd2
  } rx_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  in_t         req_data = '0;
  logic        evt_valid;
  logic        evt_stall = 1'b0;
  out_t        evt_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  keyboard_auto_repeat dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_data),
    .out_valid_o (evt_valid),
    .out_stall_i (evt_stall),
    .out_data_o  (evt_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the key table, updated on every accepted request, and of the registers.
  mode_e             key_state [NUM_KEYS];
  logic [TIME_W-1:0] key_held  [NUM_KEYS];
  logic [TIME_W-1:0] first_delay;
  logic [TIME_W-1:0] next_delay;
  logic [MASK_W-1:0] hold_mask;

  out_t        pending_events [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  logic [KEY_CODE_W-1:0] key_pool [8];

  function automatic out_t make_event(int unsigned key, logic release_evt);
    out_t e;
    e.out_key    = KEY_CODE_W'(key);
    e.is_release = release_evt;
    e.last       = 1'b0;
    return e;
  endfunction

  function automatic void predict_key_events(in_t req);
    out_t             evts [$];
    logic [TIME_W:0]  sum;
    logic [TIME_W-1:0] t;
    logic             may_repeat;
    case (req.kind)
      KIND_PRESS: begin
        if (req.key_code < NUM_KEYS) begin
          key_state[req.key_code] = MODE_PRESSED;
          key_held[req.key_code]  = '0;
          evts.push_back(make_event(req.key_code, 1'b0));
        end
      end
      KIND_RELEASE: begin
        if (req.key_code < NUM_KEYS && key_state[req.key_code] != MODE_IDLE) begin
          key_state[req.key_code] = MODE_IDLE;
          evts.push_back(make_event(req.key_code, 1'b1));
        end
      end
      KIND_TICK: begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (key_state[k] == MODE_IDLE) continue;
          sum = {1'b0, key_held[k]} + (TIME_W + 1)'(req.elapsed);
          t = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
          key_held[k] = t;
          may_repeat = !hold_mask[k];
          if (key_state[k] == MODE_PRESSED && may_repeat && t >= first_delay) begin
            key_state[k] = MODE_REPEATING;
            key_held[k]  = '0;
            evts.push_back(make_event(k, 1'b0));
          end else if (key_state[k] == MODE_REPEATING && t >= next_delay) begin
            key_held[k] = '0;
            evts.push_back(make_event(k, 1'b0));
          end
        end
      end
      default: ;
    endcase
    if (evts.size() > 0) evts[evts.size()-1].last = 1'b1;
    foreach (evts[i]) pending_events.push_back(evts[i]);
  endfunction

  // Receiver stall pattern: segments of free flow, solid stalls and choppy stalls.
  rx_mode_e    rx_mode = RX_FREE;
  int unsigned rx_left = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 12) : $urandom_range(8, 80);
    end
    rx_left--;
    case (rx_mode)
      RX_BLOCKED: evt_stall <= 1'b1;
      RX_CHOPPY:  evt_stall <= ($urandom_range(0, 2) == 0);
      default:    evt_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && evt_valid && !evt_stall) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event: out_key %0d, is_release %0d, last %0d",
               evt_data.out_key, evt_data.is_release, evt_data.last);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (evt_data.out_key !== want.out_key) begin
          $error("out_key: expected %0d, got %0d", want.out_key, evt_data.out_key);
          mismatches++;
        end
        if (evt_data.is_release !== want.is_release) begin
          $error("is_release: expected %0d, got %0d", want.is_release, evt_data.is_release);
          mismatches++;
        end
        if (evt_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, evt_data.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic in_t mk(logic [1:0] kind, logic [KEY_CODE_W-1:0] key,
                             logic [ELAPSED_W-1:0] elapsed);
    in_t r;
    r.kind     = kind;
    r.key_code = key;
    r.elapsed  = elapsed;
    return r;
  endfunction

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  // Leaves valid high on return, so back-to-back requests need no gap.
  task automatic send_request(in_t req);
    @(negedge clk);
    req_valid <= 1'b1;
    req_data  <= req;
    do @(posedge clk); while (req_stall);
    predict_key_events(req);
  endtask

  task automatic issue(in_t req);
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 15));
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send_request(req);
  endtask

  // Stops sending and waits until every expected event has come; a tick with
  // no event may still be walking the table, hence the settle time after.
  task automatic drain();
    idle_cycles(1);
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_START_DELAY:    first_delay = value[TIME_W-1:0];
      REG_REPEAT_DELAY:   next_delay  = value[TIME_W-1:0];
      REG_NO_REPEAT_MASK: hold_mask   = value[MASK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_delays(logic [31:0] start_d, logic [31:0] repeat_d, logic [63:0] mask);
    drain();
    write_reg(REG_START_DELAY, {32'd0, start_d});
    write_reg(REG_REPEAT_DELAY, {32'd0, repeat_d});
    write_reg(REG_NO_REPEAT_MASK, mask);
  endtask

  // Runs at the reset settings: first repeat, later repeats, release of an
  // idle key, press of a held key and the unused kind.
  task automatic test_reset_settings();
    issue(mk(KIND_PRESS, 6'd0, 24'h000000));
    issue(mk(KIND_PRESS, 6'd63, 24'hFFFFFF));
    issue(mk(KIND_TICK, 6'd17, 24'd0));
    issue(mk(KIND_TICK, 6'd0, 24'hFFFFFF));
    issue(mk(KIND_TICK, 6'd63, 24'd400_000));
    issue(mk(KIND_TICK, 6'd0, 24'd100_000));
    issue(mk(KIND_RELEASE, 6'd63, 24'h000000));
    issue(mk(KIND_RELEASE, 6'd63, 24'h5A5A5A));
    issue(mk(KIND_PRESS, 6'd0, 24'hABCDEF));
    issue(mk(KIND_UNUSED, 6'd5, 24'h123456));
    issue(mk(KIND_UNUSED, 6'd63, 24'hFFFFFF));
    issue(mk(KIND_TICK, 6'h2A, 24'd4_999_999));
    issue(mk(KIND_TICK, 6'h15, 24'd1));
    issue(mk(KIND_RELEASE, 6'd0, 24'hFFFFFF));
    issue(mk(KIND_TICK, 6'd0, 24'hFFFFFF));
  endtask

  task automatic test_no_repeat_mask();
    set_delays(32'd10, 32'd3, 64'h8000_0000_0000_0001);
    issue(mk(KIND_PRESS, 6'd0, 24'd0));
    issue(mk(KIND_PRESS, 6'd63, 24'd0));
    issue(mk(KIND_PRESS, 6'd5, 24'd0));
    issue(mk(KIND_TICK, 6'd0, 24'd10));
    issue(mk(KIND_TICK, 6'd0, 24'd3));
    issue(mk(KIND_TICK, 6'd0, 24'd0));
    issue(mk(KIND_RELEASE, 6'd0, 24'd0));
    issue(mk(KIND_RELEASE, 6'd63, 24'd0));
    issue(mk(KIND_RELEASE, 6'd5, 24'd0));
  endtask

  // Zero delays with every key held: a tick gives one event per key, even
  // with no elapsed time. The keys stay held for the tests that follow.
  task automatic test_zero_delays_all_keys();
    set_delays(32'd0, 32'd0, 64'd0);
    for (int k = 0; k < NUM_KEYS; k++) issue(mk(KIND_PRESS, KEY_CODE_W'(k), 24'd0));
    issue(mk(KIND_TICK, 6'd0, 24'd0));
    issue(mk(KIND_TICK, 6'd0, 24'd0));
  endtask

  // With the largest start delay only a saturated held time can reach it.
  task automatic test_held_time_saturation();
    logic [KEY_CODE_W-1:0] key;
    key = KEY_CODE_W'($urandom_range(0, NUM_KEYS - 1));
    set_delays(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
    issue(mk(KIND_PRESS, key, 24'd0));
    repeat (257) issue(mk(KIND_TICK, 6'd0, 24'hFFFFFF));
    issue(mk(KIND_RELEASE, key, 24'd0));
  endtask

  function automatic in_t random_request();
    in_t         r;
    int unsigned pick;
    pick       = $urandom_range(0, 99);
    r.elapsed  = ELAPSED_W'($urandom);
    r.key_code = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)]
                                            : KEY_CODE_W'($urandom_range(0, 63));
    if (pick < 30) begin
      r.kind = KIND_PRESS;
    end else if (pick < 55) begin
      r.kind = KIND_RELEASE;
    end else if (pick < 93) begin
      r.kind = KIND_TICK;
      case ($urandom_range(0, 9))
        0: r.elapsed = '0;
        1: r.elapsed = '1;
        2: r.elapsed = ELAPSED_W'($urandom_range(0, 2_000_000));
        default: ;
      endcase
    end else begin
      r.kind = KIND_UNUSED;
    end
    return r;
  endfunction

  task automatic test_random_traffic();
    in_t         req;
    int unsigned counted;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_delays($urandom_range(0, 20_000_000), $urandom_range(0, 5_000_000),
                      {$urandom, $urandom});
        1: set_delays(32'd0, 32'hFFFF_FFFF, '1);
        2: set_delays(32'hFFFF_FFFF, 32'd0, 64'd0);
        default: set_delays($urandom_range(0, 30_000_000), $urandom_range(0, 8_000_000),
                            {$urandom, $urandom} & {$urandom, $urandom});
      endcase
      foreach (key_pool[i]) key_pool[i] = KEY_CODE_W'($urandom_range(0, 63));
      counted = 0;
      while (counted < 30) begin
        req = random_request();
        if (req.kind != KIND_UNUSED) counted++;
        issue(req);
      end
    end
  endtask

  initial begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_state[k] = MODE_IDLE;
      key_held[k]  = '0;
    end
    first_delay = START_RESET;
    next_delay  = REPEAT_RESET;
    hold_mask   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_settings();
    test_no_repeat_mask();
    test_zero_delays_all_keys();
    test_held_time_saturation();
    test_random_traffic();
    drain();

    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
